// File: rtl/core/sba_pkg.sv
// Shared types, constants and arithmetic helpers of the scaled alpha blit engine.
package sba_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_TARGET_WIDTH  = 3'd0;
  localparam logic [2:0] REG_TARGET_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RECT_LEFT     = 3'd2;
  localparam logic [2:0] REG_RECT_TOP      = 3'd3;
  localparam logic [2:0] REG_RECT_WIDTH    = 3'd4;
  localparam logic [2:0] REG_RECT_HEIGHT   = 3'd5;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd6;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd7;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Destination bounds saturate at this size.
  localparam int TARGET_SIDE = 4096;
  // Number of quotient bits of the source coordinate, one per divider stage.
  localparam int QW = 9;
  // Default queue depths (powers of two).
  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  typedef struct packed {
    logic [12:0] target_width;
    logic [12:0] target_height;
    logic [12:0] rect_left;
    logic [12:0] rect_top;
    logic [12:0] rect_width;
    logic [12:0] rect_height;
    logic [8:0]  image_width;
    logic [8:0]  image_height;
  } cfg_t;

  // Clip result and scaled numerator of one axis.
  typedef struct packed {
    logic        ok;
    logic [21:0] num;
  } axis_t;

  // Classified item between the front and the back.
  typedef struct packed {
    logic        kind;
    logic [15:0] idx;
    logic [31:0] texel;
    logic [11:0] x;
    logic [11:0] y;
    logic [23:0] old;
    logic        vis;
    logic [21:0] numx;
    logic [21:0] numy;
  } mid_t;

  // One result transaction.
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [23:0] pix;
    logic        we;
  } res_t;

  // A source extent of zero counts as one.
  function automatic logic [8:0] src_size(logic [8:0] src);
    return (src == '0) ? 9'd1 : src;
  endfunction

  // Clips one coordinate and forms (pos - lo) * src for the later division by len.
  // The offset stays below 8191 and src below 512, so the product needs 22 bits.
  function automatic axis_t map_axis(logic [11:0] pos, logic [12:0] lo, logic [12:0] len,
                                     logic [12:0] bound, logic [8:0] src);
    logic signed [14:0] p;
    logic signed [14:0] l;
    logic signed [14:0] e;
    logic signed [14:0] b;
    logic signed [14:0] df;
    axis_t r;
    p  = signed'({3'b000, pos});
    l  = signed'({{2{lo[12]}}, lo});
    e  = l + signed'({2'b00, len});
    b  = (bound > 13'(TARGET_SIDE)) ? 15'(TARGET_SIDE) : signed'({2'b00, bound});
    df = p - l;
    r.ok  = (len != '0) && (p >= l) && (p < e) && (p < b);
    r.num = {9'b0, df[12:0]} * {13'b0, src_size(src)};
    return r;
  endfunction

  // s * a + d * (255 - a), at most 255 * 255.
  function automatic logic [15:0] blend_sum(logic [7:0] s, logic [7:0] d, logic [7:0] a);
    return ({8'b0, s} * {8'b0, a}) + ({8'b0, d} * {8'b0, 8'hFF - a});
  endfunction

  // Truncating division by 255, exact for sums up to 255 * 255.
  function automatic logic [7:0] div255(logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + {9'b0, v[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// File: rtl/core/scaled_alpha_blit.sv
// Top level of the scaled alpha blit engine.
// The block takes one transaction per cycle on each side unless full or empty holds that
// side: load transactions write a texel into a 65536-entry store, pixel transactions
// return one result each, in order. A pixel result passes the front register, the middle
// queue, the pipeline entry stage, the nine-stage quotient pipeline that maps a destination
// coordinate to a source texel, then the address, store read and blend stages and the write
// into the result queue. Queues on both sides let either neighbor stall without stopping
// the other side until they fill.
module scaled_alpha_blit import sba_pkg::*; #(
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [15:0] texel_index_i,
  input  logic [7:0]  texel_red_i,
  input  logic [7:0]  texel_green_i,
  input  logic [7:0]  texel_blue_i,
  input  logic [7:0]  texel_alpha_i,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  input  logic [23:0] old_pixel_i,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] out_x_o,
  output logic [11:0] out_y_o,
  output logic [23:0] new_pixel_o,
  output logic        write_enable_o
);

  cfg_t cfg_q;
  mid_t mid_in, mid_out;
  logic mid_push, mid_full, mid_pop, mid_empty, accept;
  res_t res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_width  <= 13'd1;
      cfg_q.target_height <= 13'd1;
      cfg_q.rect_left     <= '0;
      cfg_q.rect_top      <= '0;
      cfg_q.rect_width    <= '0;
      cfg_q.rect_height   <= '0;
      cfg_q.image_width   <= 9'd1;
      cfg_q.image_height  <= 9'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET_WIDTH:  cfg_q.target_width  <= cfg_data_i;
        REG_TARGET_HEIGHT: cfg_q.target_height <= cfg_data_i;
        REG_RECT_LEFT:     cfg_q.rect_left     <= cfg_data_i;
        REG_RECT_TOP:      cfg_q.rect_top      <= cfg_data_i;
        REG_RECT_WIDTH:    cfg_q.rect_width    <= cfg_data_i;
        REG_RECT_HEIGHT:   cfg_q.rect_height   <= cfg_data_i;
        REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data_i[8:0];
        REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Input handshake.
  assign full   = mid_full;
  assign accept = push && !mid_full;

  sba_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .kind_i        (kind_i),
    .texel_index_i (texel_index_i),
    .texel_i       ({texel_red_i, texel_green_i, texel_blue_i, texel_alpha_i}),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .old_pixel_i   (old_pixel_i),
    .mid_full_i    (mid_full),
    .mid_push_o    (mid_push),
    .mid_o         (mid_in)
  );

  // Queue between the front and the back.
  sba_fifo #(
    .W     ($bits(mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  sba_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_empty_i (mid_empty),
    .mid_i       (mid_out),
    .mid_pop_o   (mid_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign out_x_o        = res.x;
  assign out_y_o        = res.y;
  assign new_pixel_o    = res.pix;
  assign write_enable_o = res.we;

  // The middle queue is never reported full and empty at once.
  a_mid_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mid_full && mid_empty))
    else $error("middle queue full and empty together");

  // The front never offers a transaction the queue cannot take.
  a_front_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mid_push && mid_full))
    else $error("front pushed into a full queue");

  // An accepted transaction reaches the queue in the next cycle unless it is full.
  a_front_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (mid_push || mid_full))
    else $error("accepted transaction lost in the front stage");

endmodule

// File: rtl/core/sba_fifo.sv
// Small first-in first-out queue with registered pointers and a fill count.
module sba_fifo import sba_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = MID_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  // Handshake on both sides.
  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Pointer and count update.
  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/sba_front.sv
// Front end: accepts items, clips pixel coordinates and forms the scaled numerators.
module sba_front import sba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        accept_i,
  input  logic        kind_i,
  input  logic [15:0] texel_index_i,
  input  logic [31:0] texel_i,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  input  logic [23:0] old_pixel_i,
  input  logic        mid_full_i,
  output logic        mid_push_o,
  output mid_t        mid_o
);

  axis_t ax, ay;
  mid_t  f_d, f_q;
  logic  vld_q, vld_d;

  // Classify the incoming transaction.
  always_comb begin
    ax = map_axis(pixel_x_i, cfg_i.rect_left, cfg_i.rect_width, cfg_i.target_width,
                  cfg_i.image_width);
    ay = map_axis(pixel_y_i, cfg_i.rect_top, cfg_i.rect_height, cfg_i.target_height,
                  cfg_i.image_height);
    f_d.kind  = kind_i;
    f_d.idx   = texel_index_i;
    f_d.texel = texel_i;
    f_d.x     = pixel_x_i;
    f_d.y     = pixel_y_i;
    f_d.old   = old_pixel_i;
    f_d.vis   = ax.ok && ay.ok;
    f_d.numx  = ax.num;
    f_d.numy  = ay.num;
  end

  // The stage holds while the queue is full.
  assign vld_d      = mid_full_i ? vld_q : accept_i;
  assign mid_push_o = vld_q && !mid_full_i;
  assign mid_o      = f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!mid_full_i) begin
      f_q <= f_d;
    end
  end

endmodule

// File: rtl/core/sba_back.sv
// Back end: divides to source coordinates, accesses the texel store and blends.
module sba_back import sba_pkg::*; #(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic mid_empty_i,
  input  mid_t mid_i,
  output logic mid_pop_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  typedef struct packed {
    logic        vld;
    logic        kind;
    logic [15:0] idx;
    logic [31:0] texel;
    logic [11:0] x;
    logic [11:0] y;
    logic [23:0] old;
    logic        vis;
    logic [21:0] remx;
    logic [21:0] remy;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
  } dv_t;

  typedef struct packed {
    logic        vld;
    logic        kind;
    logic [15:0] addr;
    logic [31:0] texel;
    logic [11:0] x;
    logic [11:0] y;
    logic [23:0] old;
    logic        vis;
  } ad_t;

  typedef struct packed {
    logic        vld;
    logic        kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [23:0] old;
    logic        we;
    logic [15:0] rs;
    logic [15:0] gs;
    logic [15:0] bs;
  } pr_t;

  logic        en, out_full, out_push;
  dv_t         dv_q [QW+1];
  ad_t         ad_d, ad_q, m_q;
  pr_t         p_d, p_q;
  logic [31:0] mem_q [65536];
  logic [31:0] rd_q;
  logic [8:0]  scx, scy, sx, sy;
  logic [17:0] prod;
  res_t        res_d;

  // The whole pipeline advances unless the result queue is full.
  assign en        = !out_full;
  assign mid_pop_o = en && !mid_empty_i;
  assign scx       = src_size(cfg_i.image_width);
  assign scy       = src_size(cfg_i.image_height);

  // Entry stage of the quotient pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= '0;
    end else if (en) begin
      dv_q[0].vld   <= !mid_empty_i;
      dv_q[0].kind  <= mid_i.kind;
      dv_q[0].idx   <= mid_i.idx;
      dv_q[0].texel <= mid_i.texel;
      dv_q[0].x     <= mid_i.x;
      dv_q[0].y     <= mid_i.y;
      dv_q[0].old   <= mid_i.old;
      dv_q[0].vis   <= mid_i.vis;
      dv_q[0].remx  <= mid_i.numx;
      dv_q[0].remy  <= mid_i.numy;
      dv_q[0].qx    <= '0;
      dv_q[0].qy    <= '0;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int SH = QW - 1 - g;
    logic [21:0] dx, dy;
    dv_t nx;
    always_comb begin
      dx = 22'(cfg_i.rect_width) << SH;
      dy = 22'(cfg_i.rect_height) << SH;
      nx = dv_q[g];
      if (dv_q[g].remx >= dx) begin
        nx.remx   = dv_q[g].remx - dx;
        nx.qx[SH] = 1'b1;
      end
      if (dv_q[g].remy >= dy) begin
        nx.remy   = dv_q[g].remy - dy;
        nx.qy[SH] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[g+1] <= '0;
      end else if (en) begin
        dv_q[g+1] <= nx;
      end
    end
  end

  // Clamp the source coordinates and form the store address.
  always_comb begin
    sx   = (dv_q[QW].qx >= scx) ? scx - 9'd1 : dv_q[QW].qx;
    sy   = (dv_q[QW].qy >= scy) ? scy - 9'd1 : dv_q[QW].qy;
    prod = {9'b0, sy} * {9'b0, scx};
    ad_d.vld   = dv_q[QW].vld;
    ad_d.kind  = dv_q[QW].kind;
    ad_d.addr  = (dv_q[QW].kind == KIND_LOAD) ? dv_q[QW].idx : prod[15:0] + {7'b0, sx};
    ad_d.texel = dv_q[QW].texel;
    ad_d.x     = dv_q[QW].x;
    ad_d.y     = dv_q[QW].y;
    ad_d.old   = dv_q[QW].old;
    ad_d.vis   = dv_q[QW].vis;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ad_q <= '0;
      m_q  <= '0;
    end else if (en) begin
      ad_q <= ad_d;
      m_q  <= ad_q;
    end
  end

  // Texel store: loads write, pixels read, both in item order.
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ad_q.vld && (ad_q.kind == KIND_LOAD)) begin
        mem_q[ad_q.addr] <= ad_q.texel;
      end
      rd_q <= mem_q[ad_q.addr];
    end
  end

  // Blend products; a full alpha reproduces the texel exactly.
  always_comb begin
    p_d.vld  = m_q.vld;
    p_d.kind = m_q.kind;
    p_d.x    = m_q.x;
    p_d.y    = m_q.y;
    p_d.old  = m_q.old;
    p_d.we   = m_q.vis && (rd_q[7:0] != 8'h00);
    p_d.rs   = blend_sum(rd_q[31:24], m_q.old[23:16], rd_q[7:0]);
    p_d.gs   = blend_sum(rd_q[23:16], m_q.old[15:8], rd_q[7:0]);
    p_d.bs   = blend_sum(rd_q[15:8], m_q.old[7:0], rd_q[7:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else if (en) begin
      p_q <= p_d;
    end
  end

  // Final division and result assembly.
  always_comb begin
    res_d.x   = p_q.x;
    res_d.y   = p_q.y;
    res_d.we  = p_q.we;
    res_d.pix = p_q.we ? {div255(p_q.rs), div255(p_q.gs), div255(p_q.bs)} : p_q.old;
  end

  assign out_push = en && p_q.vld && (p_q.kind == KIND_PIXEL);

  sba_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (res_d),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (res_o),
    .empty_o (empty_o)
  );

endmodule
